### rtl/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg: shared types and constants of the positional list
// request kinds, fixed field widths and the per-cell command
// ----------------------------------------------------------------------------
package plm_pkg;

	localparam int unsigned POS_W   = 5;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned LIMIT_W = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	typedef enum logic [KIND_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_LOCATE = 2'd2,
		REQ_GET    = 2'd3
	} req_kind_t;

	typedef struct packed {
		logic ins;
		logic del;
	} cell_cmd_t;

endpackage

### rtl/plm_if.sv
// ----------------------------------------------------------------------------
// plm_req_if / plm_rsp_if: request and result channels
// valid/ready handshake, a transaction moves when both are high
// ----------------------------------------------------------------------------
interface plm_req_if;
	logic                             valid;
	logic                             ready;
	logic [plm_pkg::KIND_W-1:0]       req_type;
	logic [plm_pkg::POS_W-1:0]        position;
	logic signed [plm_pkg::VALUE_W-1:0] value;

	modport source (output valid, output req_type, output position, output value,
		input ready);
	modport sink (input valid, input req_type, input position, input value,
		output ready);
endinterface

interface plm_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               ok;
	logic signed [plm_pkg::VALUE_W-1:0] read_value;
	logic [plm_pkg::POS_W-1:0]          found_position;
	logic [plm_pkg::POS_W-1:0]          entry_count;
	logic                               is_empty;

	modport source (output valid, output ok, output read_value, output found_position,
		output entry_count, output is_empty, input ready);
	modport sink (input valid, input ok, input read_value, input found_position,
		input entry_count, input is_empty, output ready);
endinterface

### rtl/plm_cell.sv
// ----------------------------------------------------------------------------
// plm_cell: one list entry
// holds a word, shifts from its neighbors on insert/delete, compares to key
// ----------------------------------------------------------------------------
module plm_cell #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned IDX_W      = 4,
	parameter int unsigned INDEX      = 0
) (
	input  logic                  clk,
	input  plm_pkg::cell_cmd_t    cmd,
	input  logic [IDX_W-1:0]      target,
	input  logic [DATA_WIDTH-1:0] key,
	input  logic [DATA_WIDTH-1:0] left_word,
	input  logic [DATA_WIDTH-1:0] right_word,
	output logic [DATA_WIDTH-1:0] word,
	output logic                  match
);
	import plm_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [DATA_WIDTH-1:0] word_q;

	always_ff @(posedge clk) begin
		priority if (cmd.ins && MY_IDX == target) begin
			word_q <= key;
		end else if (cmd.ins && MY_IDX > target) begin
			word_q <= left_word;
		end else if (cmd.del && MY_IDX >= target) begin
			word_q <= right_word;
		end else begin
			word_q <= word_q;
		end
	end

	assign word  = word_q;
	assign match = (word_q == key);

endmodule

### rtl/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete: ordered list of signed words
// chain of entry cells with insert, delete, locate and get by position
// ----------------------------------------------------------------------------
// usage:
//   req channel carries req_type, position (1-based) and value; rsp channel
//   returns one transaction per request with ok, read_value, found_position,
//   entry_count and is_empty after the request.
//   cfg_wr_en/cfg_wr_data write capacity_limit; write only while idle.
// timing and throughput:
//   a request is processed in the cycle it is accepted; its result sits in
//   the output register in the next cycle. one request per cycle is taken
//   unless stalled; the cell chain shifts and compares all entries at once.
// reset:
//   arst_n clears the entry count and the valid flag and sets the limit to
//   16; entry words are not cleared, only entries below the count are read.
// stall:
//   while a result waits and rsp.ready is low, req.ready drops; the list
//   holds its contents until the result is taken.
// ----------------------------------------------------------------------------
module positional_list_insert_delete #(
	parameter int unsigned CAPACITY   = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	plm_req_if.sink                      req,
	plm_rsp_if.source                    rsp,
	input  logic                         cfg_wr_en,
	input  logic [plm_pkg::LIMIT_W-1:0]  cfg_wr_data
);
	import plm_pkg::*;

	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [LIMIT_W-1:0]    limit_q;
	logic [CNT_W-1:0]      count_q;
	logic                  rsp_valid_q;
	logic                  ok_q;
	logic [VALUE_W-1:0]    rd_q;
	logic [POS_W-1:0]      found_q;
	logic [POS_W-1:0]      cnt_out_q;
	logic                  empty_q;

	logic                  accept;
	req_kind_t             kind;
	logic [CMP_W-1:0]      pos_c;
	logic [CMP_W-1:0]      cnt_c;
	logic [CMP_W-1:0]      lim_c;
	logic [CMP_W-1:0]      cap_c;
	logic                  ins_ok;
	logic                  rd_ok;
	logic [IDX_W-1:0]      idx;
	logic [DATA_WIDTH-1:0] key;
	cell_cmd_t             cmd;
	logic [DATA_WIDTH-1:0] words [CAPACITY];
	logic [CAPACITY-1:0]   match;
	logic                  any_match;
	logic [POS_W-1:0]      found_pos;
	logic [CNT_W-1:0]      count_next;
	logic                  ok_d;
	logic [VALUE_W-1:0]    rd_d;

	assign accept    = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign kind      = req_kind_t'(req.req_type);
	assign key       = DATA_WIDTH'(req.value);
	assign idx       = IDX_W'(req.position - POS_W'(1));

	assign pos_c = CMP_W'(req.position);
	assign cnt_c = CMP_W'(count_q);
	assign cap_c = CMP_W'(CAPACITY);
	assign lim_c = (CMP_W'(limit_q) > cap_c) ? cap_c : CMP_W'(limit_q);

	assign ins_ok = (pos_c != '0) && ((pos_c - CMP_W'(1)) <= cnt_c) && (cnt_c < lim_c);
	assign rd_ok  = (pos_c != '0) && (pos_c <= cnt_c);

	assign cmd.ins = accept && (kind == REQ_INSERT) && ins_ok;
	assign cmd.del = accept && (kind == REQ_DELETE) && rd_ok;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;
		logic                  hit;

		if (i == 0) begin : g_first
			assign left_w = key;
		end else begin : g_mid_l
			assign left_w = words[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = words[i];
		end else begin : g_mid_r
			assign right_w = words[i+1];
		end

		plm_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.IDX_W      (IDX_W),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.target     (idx),
			.key        (key),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (words[i]),
			.match      (hit)
		);

		assign match[i] = hit && (CNT_W'(i) < count_q);
	end

	// first match wins
	always_comb begin
		any_match = 1'b0;
		found_pos = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match[i]) begin
				any_match = 1'b1;
				found_pos = POS_W'(i + 1);
			end
		end
	end

	always_comb begin
		count_next = count_q;
		ok_d       = 1'b0;
		rd_d       = '0;
		unique case (kind)
			REQ_INSERT: begin
				ok_d = ins_ok;
				if (ins_ok) begin
					count_next = count_q + CNT_W'(1);
				end
			end
			REQ_DELETE: begin
				ok_d = rd_ok;
				if (rd_ok) begin
					count_next = count_q - CNT_W'(1);
					rd_d       = VALUE_W'(words[idx]);
				end
			end
			REQ_LOCATE: begin
				ok_d = any_match;
			end
			REQ_GET: begin
				ok_d = rd_ok;
				if (rd_ok) begin
					rd_d = VALUE_W'(words[idx]);
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q      <= ok_d;
			rd_q      <= rd_d;
			found_q   <= (kind == REQ_LOCATE) ? found_pos : '0;
			cnt_out_q <= POS_W'(count_next);
			empty_q   <= (count_next == '0);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.ok             = ok_q;
	assign rsp.read_value     = rd_q;
	assign rsp.found_position = found_q;
	assign rsp.entry_count    = cnt_out_q;
	assign rsp.is_empty       = empty_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count changed without a transaction");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !ok_q) |-> (rd_q == '0 && found_q == '0))
		else $error("failed request carries data");

endmodule

### test/tb_positional_list_insert_delete.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_list_insert_delete: self-checking bench for the positional list
// a queue-fed driver sends insert, delete, locate and get requests. a mirror of
// the list predicts every response, and a monitor checks each response
// transaction field by field. phases change the capacity limit and the idle
// and stall rates on both channels.
// ----------------------------------------------------------------------------
module tb_positional_list_insert_delete;
	import plm_pkg::*;

	localparam int LIST_DEPTH  = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 4;

	typedef struct packed {
		req_kind_t                  kind;
		logic [POS_W-1:0]           pos;
		logic signed [VALUE_W-1:0]  word;
	} request_t;

	typedef struct packed {
		logic                       ok;
		logic signed [VALUE_W-1:0]  read_value;
		logic [POS_W-1:0]           found_position;
		logic [POS_W-1:0]           entry_count;
		logic                       is_empty;
	} response_t;

	typedef struct packed {
		logic [LIST_DEPTH-1:0][VALUE_W-1:0] words;
		logic [POS_W-1:0]                   count;
		logic [LIMIT_W-1:0]                 limit;
	} list_state_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [LIMIT_W-1:0] cfg_wr_data;

	plm_req_if req_ch ();
	plm_rsp_if rsp_ch ();

	positional_list_insert_delete DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	request_t    queued_requests[$];
	response_t   awaited_responses[$];
	list_state_t list_mirror;
	list_state_t plan_list;
	int          send_idle_pct;
	int          stall_pct;
	int          mismatch_count;
	int          cycle_count;
	bit          growing;

	task automatic apply_request(input request_t rq, inout list_state_t st,
		output response_t res);
		int eff;
		int p;
		int n;
		int j;
		res = '0;
		eff = (st.limit > LIST_DEPTH) ? LIST_DEPTH : int'(st.limit);
		p = int'(rq.pos);
		n = int'(st.count);
		case (rq.kind)
			REQ_INSERT: begin
				if (p >= 1 && p <= n + 1 && n < eff) begin
					for (j = n; j >= p; j--)
						st.words[j] = st.words[j-1];
					st.words[p-1] = rq.word;
					n++;
					res.ok = 1'b1;
				end
			end
			REQ_DELETE: begin
				if (p >= 1 && p <= n) begin
					res.read_value = st.words[p-1];
					for (j = p; j < n; j++)
						st.words[j-1] = st.words[j];
					n--;
					res.ok = 1'b1;
				end
			end
			REQ_LOCATE: begin
				for (j = 0; j < n; j++) begin
					if (!res.ok && st.words[j] == rq.word) begin
						res.found_position = POS_W'(j + 1);
						res.ok = 1'b1;
					end
				end
			end
			default: begin
				if (p >= 1 && p <= n) begin
					res.read_value = st.words[p-1];
					res.ok = 1'b1;
				end
			end
		endcase
		st.count = POS_W'(n);
		res.entry_count = POS_W'(n);
		res.is_empty = (n == 0);
	endtask

	task automatic add_request(input req_kind_t kind, input int pos,
		input logic [VALUE_W-1:0] word);
		request_t  rq;
		response_t ignored;
		rq.kind = kind;
		rq.pos = POS_W'(pos);
		rq.word = word;
		apply_request(rq, plan_list, ignored);
		queued_requests.push_back(rq);
	endtask

	function automatic logic [VALUE_W-1:0] pick_word();
		case ($urandom_range(0, 5))
			0: pick_word = $urandom_range(0, 7);
			1: begin
				case ($urandom_range(0, 3))
					0: pick_word = 32'h8000_0000;
					1: pick_word = 32'h7fff_ffff;
					2: pick_word = 32'hffff_ffff;
					default: pick_word = '0;
				endcase
			end
			default: pick_word = $urandom;
		endcase
	endfunction

	task automatic plan_random(input int total);
		int i;
		int r;
		int n;
		int pos;
		req_kind_t kind;
		logic [VALUE_W-1:0] word;
		for (i = 0; i < total; i++) begin
			n = int'(plan_list.count);
			if ($urandom_range(0, 59) == 0)
				growing = !growing;
			r = $urandom_range(0, 99);
			if (growing)
				kind = (r < 50) ? REQ_INSERT : (r < 65) ? REQ_DELETE :
					(r < 82) ? REQ_LOCATE : REQ_GET;
			else
				kind = (r < 20) ? REQ_INSERT : (r < 55) ? REQ_DELETE :
					(r < 75) ? REQ_LOCATE : REQ_GET;
			if ($urandom_range(0, 9) == 0)
				pos = $urandom_range(0, 31);
			else if (kind == REQ_INSERT)
				pos = $urandom_range(1, n + 1);
			else if (n > 0)
				pos = $urandom_range(1, n);
			else
				pos = $urandom_range(0, 31);
			word = pick_word();
			if (kind == REQ_LOCATE && n > 0 && $urandom_range(0, 9) < 6)
				word = plan_list.words[$urandom_range(0, n - 1)];
			add_request(kind, pos, word);
		end
	endtask

	task automatic wait_idle();
		do begin
			while (queued_requests.size() != 0 || req_ch.valid ||
				awaited_responses.size() != 0)
				@(posedge clk);
			repeat (SETTLE) @(posedge clk);
		end while (queued_requests.size() != 0 || req_ch.valid ||
			awaited_responses.size() != 0);
	endtask

	task automatic run_phase(input int limit, input int idle, input int stall,
		input int total);
		wait_idle();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= LIMIT_W'(limit);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		list_mirror.limit = LIMIT_W'(limit);
		plan_list.limit = LIMIT_W'(limit);
		send_idle_pct = idle;
		stall_pct = stall;
		plan_random(total);
	endtask

	task automatic report_field(input string field, input logic [VALUE_W-1:0] want,
		input logic [VALUE_W-1:0] got);
		$display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
		mismatch_count++;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// driver: predict on acceptance, then present the next request or idle
	always @(posedge clk) begin
		request_t  cur;
		response_t res;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				cur.kind = req_kind_t'(req_ch.req_type);
				cur.pos = req_ch.position;
				cur.word = req_ch.value;
				apply_request(cur, list_mirror, res);
				awaited_responses.push_back(res);
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (queued_requests.size() != 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
					cur = queued_requests.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= cur.kind;
					req_ch.position <= cur.pos;
					req_ch.value <= cur.word;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each response transaction against the oldest prediction
	always @(posedge clk) begin
		response_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (awaited_responses.size() == 0) begin
					$display(
						"%0t ns: response expected none actual ok=%0b read=%0h found=%0d count=%0d",
						$time, rsp_ch.ok, rsp_ch.read_value, rsp_ch.found_position,
						rsp_ch.entry_count);
					mismatch_count++;
				end else begin
					want = awaited_responses.pop_front();
					if (rsp_ch.ok !== want.ok)
						report_field("ok", want.ok, rsp_ch.ok);
					if (rsp_ch.read_value !== want.read_value)
						report_field("read_value", want.read_value, rsp_ch.read_value);
					if (rsp_ch.found_position !== want.found_position)
						report_field("found_position", want.found_position,
							rsp_ch.found_position);
					if (rsp_ch.entry_count !== want.entry_count)
						report_field("entry_count", want.entry_count, rsp_ch.entry_count);
					if (rsp_ch.is_empty !== want.is_empty)
						report_field("is_empty", want.is_empty, rsp_ch.is_empty);
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = '0;
		req_ch.position = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		mismatch_count = 0;
		cycle_count = 0;
		growing = 1'b1;
		list_mirror = '0;
		list_mirror.limit = LIMIT_RESET;
		plan_list = list_mirror;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// empty list corner cases, then a short mixed sequence with duplicates
		add_request(REQ_INSERT, 0, 32'd5);
		add_request(REQ_GET,    0, 32'd0);
		add_request(REQ_DELETE, 1, 32'd0);
		add_request(REQ_LOCATE, 0, 32'd0);
		add_request(REQ_INSERT, 2, 32'd9);
		add_request(REQ_INSERT, 1, 32'h8000_0000);
		add_request(REQ_INSERT, 2, 32'h7fff_ffff);
		add_request(REQ_INSERT, 1, 32'hffff_ffff);
		add_request(REQ_INSERT, 4, 32'd0);
		add_request(REQ_INSERT, 6, 32'd7);
		add_request(REQ_INSERT, 3, 32'hffff_ffff);
		add_request(REQ_LOCATE, 0, 32'hffff_ffff);
		add_request(REQ_LOCATE, 31, 32'h7fff_ffff);
		add_request(REQ_LOCATE, 1, 32'd12345);
		add_request(REQ_GET,    5, 32'd0);
		add_request(REQ_GET,    6, 32'd0);
		add_request(REQ_GET,    31, 32'd0);
		add_request(REQ_DELETE, 31, 32'd0);
		add_request(REQ_DELETE, 1, 32'd0);
		add_request(REQ_LOCATE, 0, 32'hffff_ffff);
		add_request(REQ_DELETE, 4, 32'd0);
		add_request(REQ_DELETE, 0, 32'd0);
		add_request(REQ_GET,    16, 32'd0);
		add_request(REQ_INSERT, 16, 32'd3);

		run_phase(16,  0,  0, 300);
		run_phase(16, 52,  0, 300);
		run_phase(4,   0, 52, 250);
		run_phase(16, 25, 25, 300);
		run_phase(1,  25, 25, 150);
		run_phase(0,   0,  0,  60);
		run_phase(31, 52,  0, 250);
		run_phase(8,   0, 52, 200);
		run_phase(16, 25, 25, 150);
		wait_idle();

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### positional_list_insert_delete.f
rtl/plm_pkg.sv
rtl/plm_if.sv
rtl/plm_cell.sv
rtl/positional_list_insert_delete.sv
test/tb_positional_list_insert_delete.sv
